// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== design/dlr_pkg.sv =====
package dlr_pkg;

  localparam int MAX_CHANNELS    = 8;
  localparam int PHASE_FRAC_BITS = 24;

  localparam int NUM_CH_PORTS = 8;
  localparam int PCM_W        = 16;
  localparam int OUT_W        = 24;
  localparam int IDX_W        = 32;
  localparam int STEP_W       = 27;
  localparam int CC_W         = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 27;
  localparam int MAX_RESULTS  = 3;
  localparam int RES_CNT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 1'd1;

  localparam logic [CC_W-1:0]   CHANNEL_COUNT_RST = 4'd1;
  localparam logic [STEP_W-1:0] PHASE_STEP_RST    = 27'd16777216;

  typedef logic signed [PCM_W-1:0] pcm_t;
  typedef pcm_t [NUM_CH_PORTS-1:0] frame_t;

endpackage

// ===== design/dlr_mono.sv =====
// Channel downmix: serial accumulate, then restoring divide by the count.
module dlr_mono #(
  parameter int MAX_CHANNELS = dlr_pkg::MAX_CHANNELS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [dlr_pkg::CC_W-1:0] nch_i,
  input  dlr_pkg::frame_t         frame_i,
  output logic                    done_o,
  output dlr_pkg::pcm_t           mono_o
);

  localparam int CW   = dlr_pkg::CC_W;
  localparam int SUMW = dlr_pkg::PCM_W + $clog2(MAX_CHANNELS);
  localparam int MAGW = SUMW;
  localparam int STW  = $clog2(MAGW + 1);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_ACC  = 4'b0010,
    M_DIV  = 4'b0100,
    M_FIN  = 4'b1000
  } mono_state_e;

  mono_state_e          state_q, state_d;
  logic signed [SUMW-1:0] acc_q, acc_d, acc_sum;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        nch_q, nch_d;
  logic [MAGW-1:0]      quo_q, quo_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [STW-1:0]       step_q, step_d;
  logic                 neg_q, neg_d;
  logic [CW:0]          trial;
  logic [MAGW-1:0]      quo_signed;

  assign acc_sum = acc_q + SUMW'($signed(frame_i[cnt_q[2:0]]));
  assign trial   = {rem_q, quo_q[MAGW-1]};

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    nch_d   = nch_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    neg_d   = neg_q;
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          acc_d   = '0;
          cnt_d   = '0;
          nch_d   = nch_i;
          state_d = M_ACC;
        end
      end
      M_ACC: begin
        acc_d = acc_sum;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == nch_q - 1'b1) begin
          neg_d   = acc_sum[SUMW-1];
          quo_d   = acc_sum[SUMW-1] ? MAGW'(-acc_sum) : MAGW'(acc_sum);
          rem_d   = '0;
          step_d  = '0;
          state_d = M_DIV;
        end
      end
      M_DIV: begin
        // one quotient bit per cycle
        if (trial >= {1'b0, nch_q}) begin
          rem_d = CW'(trial - {1'b0, nch_q});
          quo_d = {quo_q[MAGW-2:0], 1'b1};
        end else begin
          rem_d = trial[CW-1:0];
          quo_d = {quo_q[MAGW-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STW'(MAGW - 1)) state_d = M_FIN;
      end
      M_FIN: begin
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    nch_q  <= nch_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    neg_q  <= neg_d;
  end

  // truncation toward zero: divide magnitude, restore sign
  assign quo_signed = neg_q ? -quo_q : quo_q;
  assign mono_o     = quo_signed[dlr_pkg::PCM_W-1:0];
  assign done_o     = (state_q == M_FIN);

endmodule

// ===== design/dlr_interp.sv =====
// Interpolation datapath: registered multiply, then round to Q1.23.
module dlr_interp #(
  parameter int PHASE_FRAC_BITS = dlr_pkg::PHASE_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  dlr_pkg::pcm_t             prev_i,
  input  dlr_pkg::pcm_t             cur_i,
  input  logic [PHASE_FRAC_BITS:0]  frac_i,
  output logic signed [dlr_pkg::OUT_W-1:0] sample_o
);

  localparam int F     = PHASE_FRAC_BITS;
  localparam int PRODW = F + 19;
  localparam int NUMW  = F + 20;
  localparam logic signed [NUMW-1:0] RND = {{(NUMW-1){1'b0}}, 1'b1} << (F - 9);

  logic signed [16:0]      diff;
  logic signed [PRODW-1:0] prod_q;
  dlr_pkg::pcm_t           prev_q;
  logic signed [NUMW-1:0]  num, shifted;

  assign diff = 17'(cur_i) - 17'(prev_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= diff * $signed({1'b0, frac_i});
      prev_q <= prev_i;
    end
  end

  assign num      = (NUMW'(prev_q) <<< F) + NUMW'(prod_q);
  assign shifted  = (num + RND) >>> (F - 8);
  assign sample_o = shifted[dlr_pkg::OUT_W-1:0];

endmodule

// ===== design/downmix_linear_resampler_core.sv =====
// Downmix and linear-interpolation resampler.
// Input channel (in_valid_i/in_ready_o): one PCM frame per beat, ch0_i..ch7_i;
// only the first channel_count channels are averaged (truncated toward zero).
// Output channel (out_valid_o/out_ready_i): zero to three beats per frame,
// each a Q1.23 sample, its running index and a last-of-run flag on the final
// beat of the frame. A frame that produces no beat is silent.
// Config: cfg_we_i writes cfg_data_i into register cfg_index_i at once
// (0 = channel_count, 1 = phase_step in Q24); write only while idle.
// Timing: one frame at a time. The downmix adds one channel per cycle, then
// a restoring divider retires one quotient bit per cycle (19 bits) before
// the first result is shown. Each result passes through the check, multiply
// and output register states and then waits out any receiver stall;
// in_ready_o rises in the cycle after a check that finds no more points due,
// so after the last beat is taken the sequencer passes the check state first.
// Reset clears the phase, previous sample and index and restores register
// defaults. A stall on the output holds the beat and freezes the sequencer.
`include "assert_macros.svh"
module downmix_linear_resampler_core #(
  parameter int MAX_CHANNELS    = dlr_pkg::MAX_CHANNELS,
  parameter int PHASE_FRAC_BITS = dlr_pkg::PHASE_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dlr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [dlr_pkg::PCM_W-1:0]    ch0_i,
  input  logic signed [dlr_pkg::PCM_W-1:0]    ch1_i,
  input  logic signed [dlr_pkg::PCM_W-1:0]    ch2_i,
  input  logic signed [dlr_pkg::PCM_W-1:0]    ch3_i,
  input  logic signed [dlr_pkg::PCM_W-1:0]    ch4_i,
  input  logic signed [dlr_pkg::PCM_W-1:0]    ch5_i,
  input  logic signed [dlr_pkg::PCM_W-1:0]    ch6_i,
  input  logic signed [dlr_pkg::PCM_W-1:0]    ch7_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dlr_pkg::OUT_W-1:0]    sample_o,
  output logic [dlr_pkg::IDX_W-1:0]           sample_index_o,
  output logic                                last_of_run_o
);

  localparam int F    = PHASE_FRAC_BITS;
  localparam int PW   = F + 4;                        // phase, +/- 8.0 in QF
  localparam int ADDW = ((PW > dlr_pkg::STEP_W) ? PW : dlr_pkg::STEP_W) + 2;
  localparam int CW   = dlr_pkg::CC_W;

  localparam logic signed [PW:0]     ONE_W  = {{PW{1'b0}}, 1'b1} << F;
  localparam logic signed [PW:0]     LIM_LO = {2'b11, {(F + 3){1'b0}}};
  localparam logic signed [ADDW-1:0] LIM_HI = {{(ADDW - F - 3){1'b0}}, {(F + 3){1'b1}}};

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MIX   = 5'b00010,
    S_CHECK = 5'b00100,
    S_MUL   = 5'b01000,
    S_OUT   = 5'b10000
  } core_state_e;

  core_state_e                state_q, state_d;
  logic [CW-1:0]              chan_cnt_q;
  logic [dlr_pkg::STEP_W-1:0] step_q;
  dlr_pkg::pcm_t              prev_q, cur_q;
  logic signed [PW-1:0]       phase_q;
  logic [dlr_pkg::IDX_W-1:0]  emitted_q;
  logic [dlr_pkg::RES_CNT_W-1:0] n_q;
  dlr_pkg::frame_t            frame_q;
  logic signed [dlr_pkg::OUT_W-1:0] sample_q;
  logic                       last_q;

  logic                  in_fire, out_fire;
  logic [CW-1:0]         nch;
  logic                  mono_done;
  dlr_pkg::pcm_t         mono;
  logic                  due;
  logic signed [ADDW-1:0] adv_full;
  logic signed [PW-1:0]  phase_adv;
  logic signed [PW:0]    dec_full;
  logic signed [PW-1:0]  phase_dec;
  logic signed [PW:0]    frac_full;
  logic [F:0]            frac;
  logic                  mul_en;
  logic signed [dlr_pkg::OUT_W-1:0] interp_sample;
  logic                  last_now;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_fire    = out_valid_o && out_ready_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= dlr_pkg::CHANNEL_COUNT_RST;
      step_q     <= dlr_pkg::PHASE_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dlr_pkg::REG_CHANNEL_COUNT: chan_cnt_q <= cfg_data_i[CW-1:0];
        dlr_pkg::REG_PHASE_STEP:    step_q     <= cfg_data_i[dlr_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero count acts as one, too many saturates
  always_comb begin
    if (chan_cnt_q == '0) begin
      nch = CW'(1);
    end else if (chan_cnt_q > CW'(MAX_CHANNELS)) begin
      nch = CW'(MAX_CHANNELS);
    end else begin
      nch = chan_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_q[0] <= ch0_i;
      frame_q[1] <= ch1_i;
      frame_q[2] <= ch2_i;
      frame_q[3] <= ch3_i;
      frame_q[4] <= ch4_i;
      frame_q[5] <= ch5_i;
      frame_q[6] <= ch6_i;
      frame_q[7] <= ch7_i;
    end
  end

  // downmix starts with the accepting edge; frame_q is loaded by then
  dlr_mono #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_mono (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_fire),
    .nch_i  (nch),
    .frame_i(frame_q),
    .done_o (mono_done),
    .mono_o (mono)
  );

  // phase arithmetic
  assign due       = phase_q[PW-1] || (phase_q == '0);
  assign adv_full  = ADDW'(phase_q) + ADDW'({1'b0, step_q});
  assign phase_adv = (adv_full > LIM_HI) ? LIM_HI[PW-1:0] : adv_full[PW-1:0];
  assign dec_full  = (PW + 1)'(phase_q) - ONE_W;
  assign phase_dec = (dec_full < LIM_LO) ? LIM_LO[PW-1:0] : dec_full[PW-1:0];
  assign frac_full = (PW + 1)'(phase_q) + ONE_W;
  assign frac      = frac_full[PW] ? '0 : frac_full[F:0];
  assign last_now  = (n_q == dlr_pkg::RES_CNT_W'(dlr_pkg::MAX_RESULTS - 1)) ||
                     (!phase_adv[PW-1] && phase_adv != '0);

  assign mul_en = (state_q == S_CHECK) && due &&
                  (n_q != dlr_pkg::RES_CNT_W'(dlr_pkg::MAX_RESULTS));

  dlr_interp #(
    .PHASE_FRAC_BITS(F)
  ) u_interp (
    .clk_i   (clk_i),
    .en_i    (mul_en),
    .prev_i  (prev_q),
    .cur_i   (cur_q),
    .frac_i  (frac),
    .sample_o(interp_sample)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_MIX;
      S_MIX:   if (mono_done) state_d = S_CHECK;
      S_CHECK: state_d = mul_en ? S_MUL : S_IDLE;
      S_MUL:   state_d = S_OUT;
      S_OUT:   if (out_fire) state_d = S_CHECK;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      prev_q    <= '0;
      phase_q   <= '0;
      emitted_q <= '0;
      n_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_MIX && mono_done) begin
        n_q <= '0;
      end
      if (state_q == S_CHECK && !mul_en) begin
        // frame done: move to the next input interval
        prev_q  <= cur_q;
        phase_q <= phase_dec;
      end
      if (out_fire) begin
        emitted_q <= emitted_q + 1'b1;
        phase_q   <= phase_adv;
        n_q       <= n_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MIX && mono_done) cur_q <= mono;
    if (state_q == S_MUL) begin
      sample_q <= interp_sample;
      last_q   <= last_now;
    end
  end

  assign sample_o       = sample_q;
  assign sample_index_o = emitted_q;
  assign last_of_run_o  = last_q;

  `ASSERT_PROP(a_idx_step, clk_i, rst_ni, out_fire |=> emitted_q == $past(emitted_q) + 1'b1)
  `ASSERT_PROP(a_last_ends, clk_i, rst_ni, (out_fire && last_of_run_o) |=> ##1 in_ready_o)
  `ASSERT_NEVER(a_run_bound, clk_i, rst_ni, out_valid_o && n_q == dlr_pkg::RES_CNT_W'(dlr_pkg::MAX_RESULTS))
  `ASSERT_PROP(a_mix_done, clk_i, rst_ni, mono_done |-> state_q == S_MIX)

endmodule
